@@ design/dedup_table_newer_wins_fifo_evict_defines.svh @@
// assertion macros for the dedup table
`ifndef DEDUP_TABLE_NEWER_WINS_FIFO_EVICT_DEFINES_SVH
`define DEDUP_TABLE_NEWER_WINS_FIFO_EVICT_DEFINES_SVH
`ifndef SYNTH
`define DT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define DT_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define DT_ASSERT(lbl, prop, msg)
`define DT_ASSERT_NR(lbl, prop, msg)
`endif
`endif

@@ design/dtnw_pkg.sv @@
// types and constants shared by the dedup table modules
`timescale 1ns / 1ps
package dtnw_pkg;

  localparam int         DEPTH     = 16;
  localparam logic [4:0] CAP_RESET = 5'd16;

  typedef struct packed {
    logic [63:0] header;
    logic [63:0] parent0;
    logic [63:0] parent1;
    logic [63:0] parent2;
    logic [63:0] parent3;
    logic [63:0] mask;
    logic [31:0] age;
    logic [63:0] payload;
    logic        active;
  } rec_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_READ   = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    OC_REPLACED = 3'd0,
    OC_KEPT     = 3'd1,
    OC_APPENDED = 3'd2,
    OC_EVICTED  = 3'd3,
    OC_READ     = 3'd4
  } outcome_e;

  typedef enum logic [1:0] {
    CMD_HOLD  = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_SHIFT = 2'd2
  } cell_cmd_e;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_COMMIT = 1'b1
  } state_e;

  typedef struct packed {
    logic      sample;
    logic      valid;
    logic      rd_sel;
    cell_cmd_e cmd;
  } cell_ctrl_t;

  typedef struct packed {
    logic match;
    logic age_ok;
  } cell_stat_t;

endpackage

@@ design/dtnw_cell.sv @@
// one table slot: holds a record, compares it with an incoming key, shifts to its neighbor
`timescale 1ns / 1ps
module dtnw_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dtnw_pkg::cell_ctrl_t ctrl_i,
  input  dtnw_pkg::rec_t     cmp_i,
  input  dtnw_pkg::rec_t     wr_i,
  input  dtnw_pkg::rec_t     nxt_i,
  output dtnw_pkg::rec_t     rec_o,
  output dtnw_pkg::rec_t     rd_o,
  output dtnw_pkg::cell_stat_t stat_o
);
  import dtnw_pkg::*;

  rec_t       rec_q, rec_d;
  rec_t       rd_q, rd_d;
  cell_stat_t stat_q, stat_d;
  logic       key_eq;

  assign key_eq = (rec_q.header == cmp_i.header) && (rec_q.parent0 == cmp_i.parent0) &&
                  (rec_q.parent1 == cmp_i.parent1) && (rec_q.parent2 == cmp_i.parent2) &&
                  (rec_q.parent3 == cmp_i.parent3) && (rec_q.mask == cmp_i.mask);

  always_comb begin
    rec_d = rec_q;
    case (ctrl_i.cmd)
      CMD_LOAD:  rec_d = wr_i;
      CMD_SHIFT: rec_d = nxt_i;
      default:   rec_d = rec_q;
    endcase
  end

  // a slot past the fill level reads as zero
  always_comb begin
    stat_d = stat_q;
    rd_d   = rd_q;
    if (ctrl_i.sample) begin
      stat_d.match  = ctrl_i.valid && key_eq;
      stat_d.age_ok = cmp_i.age >= rec_q.age;
      rd_d          = (ctrl_i.rd_sel && ctrl_i.valid) ? rec_q : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
    rd_q  <= rd_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stat_q <= '0;
    end else begin
      stat_q <= stat_d;
    end
  end

  assign rec_o  = rec_q;
  assign rd_o   = rd_q;
  assign stat_o = stat_q;

endmodule

@@ design/dedup_table_newer_wins_fifo_evict.sv @@
// top level of the deduplicating record table with newer-wins replace and fifo eviction
//
//   channel   direction  handshake                    beat
//   command   in         start && !busy               op, read_slot, key, age, payload, active
//   result    out        done_o (one-cycle strobe)    outcome, slot, entry_count, rd_*
//   config    in         cfg_valid_i && cfg_ready_o   capacity
//
// an item is accepted, then committed: at the accepting edge every slot cell compares its
// record with the incoming key in parallel and latches hit, age and read data;
// the commit state then applies the replace, append or shift and registers the result.
// done_o is high for one cycle after that commit, busy is low in that cycle.
// reset empties the table (slot contents are left as they are) and sets capacity to 16.
// the result side cannot stall; cfg_ready_o is always high, writes land only while empty.
`timescale 1ns / 1ps
`include "dedup_table_newer_wins_fifo_evict_defines.svh"
module dedup_table_newer_wins_fifo_evict (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        op_i,
  input  logic [3:0]  read_slot_i,
  input  logic [63:0] key_header_i,
  input  logic [63:0] parent_word0_i,
  input  logic [63:0] parent_word1_i,
  input  logic [63:0] parent_word2_i,
  input  logic [63:0] parent_word3_i,
  input  logic [63:0] origin_mask_i,
  input  logic [31:0] snapshot_age_i,
  input  logic [63:0] record_payload_i,
  input  logic        record_active_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i,
  output logic        done_o,
  output logic [2:0]  outcome_o,
  output logic [3:0]  slot_o,
  output logic [4:0]  entry_count_o,
  output logic [63:0] rd_header_o,
  output logic [63:0] rd_parent0_o,
  output logic [63:0] rd_parent1_o,
  output logic [63:0] rd_parent2_o,
  output logic [63:0] rd_parent3_o,
  output logic [63:0] rd_mask_o,
  output logic [31:0] rd_age_o,
  output logic [63:0] rd_payload_o,
  output logic        rd_active_o
);
  import dtnw_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  state_e   state_q, state_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [4:0]    cap_q, cap_d;
  logic [CW-1:0] cap_eff;
  logic          accept;

  logic          op_q;
  logic [3:0]    rs_q;
  rec_t          req_q;
  rec_t          in_rec;

  logic          done_q, done_d;
  outcome_e      outcome_q, outcome_d;
  logic [3:0]    slot_q, slot_d;
  logic [4:0]    count_q, count_d;
  rec_t          res_q, res_d;

  cell_ctrl_t    ctrl [DEPTH];
  cell_cmd_e     cmd [DEPTH];
  rec_t          cell_rec [DEPTH];
  rec_t          cell_rd [DEPTH];
  cell_stat_t    stat [DEPTH];

  logic [DEPTH-1:0] match_vec;
  logic             hit;
  logic             hit_newer;
  logic [IW-1:0]    hit_idx;
  rec_t             rd_or;

  assign accept      = start && !busy;
  assign busy        = (state_q == ST_COMMIT);
  assign cfg_ready_o = 1'b1;

  assign in_rec.header  = key_header_i;
  assign in_rec.parent0 = parent_word0_i;
  assign in_rec.parent1 = parent_word1_i;
  assign in_rec.parent2 = parent_word2_i;
  assign in_rec.parent3 = parent_word3_i;
  assign in_rec.mask    = origin_mask_i;
  assign in_rec.age     = snapshot_age_i;
  assign in_rec.payload = record_payload_i;
  assign in_rec.active  = record_active_i;

  // capacity clamped to 1..DEPTH
  always_comb begin
    if (cap_q == 5'd0) begin
      cap_eff = CW'(1);
    end else if (int'(cap_q) > DEPTH) begin
      cap_eff = CW'(DEPTH);
    end else begin
      cap_eff = CW'(cap_q);
    end
  end

  assign cap_d = (cfg_valid_i && (fill_q == '0)) ? cfg_data_i : cap_q;

  // slot cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    rec_t nxt;
    if (i == DEPTH - 1) begin : g_last
      assign nxt = '0;
    end else begin : g_mid
      assign nxt = cell_rec[i+1];
    end

    assign ctrl[i].sample = accept;
    assign ctrl[i].valid  = int'(fill_q) > i;
    assign ctrl[i].rd_sel = (op_i == OP_READ) && (int'(read_slot_i) == i);
    assign ctrl[i].cmd    = cmd[i];
    assign match_vec[i]   = stat[i].match;

    dtnw_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl[i]),
      .cmp_i  (in_rec),
      .wr_i   (req_q),
      .nxt_i  (nxt),
      .rec_o  (cell_rec[i]),
      .rd_o   (cell_rd[i]),
      .stat_o (stat[i])
    );
  end

  // keys in the table are unique, so at most one cell hits and an or picks it
  always_comb begin
    hit       = 1'b0;
    hit_newer = 1'b0;
    hit_idx   = '0;
    rd_or     = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit       = hit | stat[i].match;
      hit_newer = hit_newer | (stat[i].match & stat[i].age_ok);
      hit_idx   = hit_idx | (stat[i].match ? IW'(i) : '0);
      rd_or     = rd_or | cell_rd[i];
    end
  end

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    done_d    = 1'b0;
    outcome_d = outcome_q;
    slot_d    = slot_q;
    count_d   = count_q;
    res_d     = res_q;
    for (int i = 0; i < DEPTH; i++) begin
      cmd[i] = CMD_HOLD;
    end
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        state_d = ST_IDLE;
        done_d  = 1'b1;
        res_d   = '0;
        if (op_q == OP_READ) begin
          outcome_d = OC_READ;
          slot_d    = rs_q;
          res_d     = rd_or;
        end else if (hit) begin
          slot_d = 4'(hit_idx);
          if (hit_newer) begin
            outcome_d = OC_REPLACED;
            for (int i = 0; i < DEPTH; i++) begin
              if (int'(hit_idx) == i) cmd[i] = CMD_LOAD;
            end
          end else begin
            outcome_d = OC_KEPT;
          end
        end else if (fill_q < cap_eff) begin
          outcome_d = OC_APPENDED;
          slot_d    = 4'(fill_q);
          fill_d    = fill_q + 1'b1;
          for (int i = 0; i < DEPTH; i++) begin
            if (int'(fill_q) == i) cmd[i] = CMD_LOAD;
          end
        end else begin
          // drop slot 0, shift the rest down, new record goes last
          outcome_d = OC_EVICTED;
          slot_d    = 4'(cap_eff - 1'b1);
          for (int i = 0; i < DEPTH; i++) begin
            if (i < int'(cap_eff) - 1) begin
              cmd[i] = CMD_SHIFT;
            end else if (i == int'(cap_eff) - 1) begin
              cmd[i] = CMD_LOAD;
            end
          end
        end
        count_d = 5'(fill_d);
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      cap_q   <= CAP_RESET;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      cap_q   <= cap_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_i;
      rs_q  <= read_slot_i;
      req_q <= in_rec;
    end
    outcome_q <= outcome_d;
    slot_q    <= slot_d;
    count_q   <= count_d;
    res_q     <= res_d;
  end

  assign done_o        = done_q;
  assign outcome_o     = outcome_q;
  assign slot_o        = slot_q;
  assign entry_count_o = count_q;
  assign rd_header_o   = res_q.header;
  assign rd_parent0_o  = res_q.parent0;
  assign rd_parent1_o  = res_q.parent1;
  assign rd_parent2_o  = res_q.parent2;
  assign rd_parent3_o  = res_q.parent3;
  assign rd_mask_o     = res_q.mask;
  assign rd_age_o      = res_q.age;
  assign rd_payload_o  = res_q.payload;
  assign rd_active_o   = res_q.active;

  `DT_ASSERT(a_unique_hit, $onehot0(match_vec), "more than one slot matched the key")
  `DT_ASSERT(a_fill_le_cap, fill_q <= cap_eff, "fill count above capacity")
  `DT_ASSERT(a_done_after_commit, (state_q == ST_COMMIT) |=> done_o, "commit without result")
  `DT_ASSERT(a_fill_on_commit, $changed(fill_q) |-> $past(busy), "fill moved outside commit")
  `DT_ASSERT_NR(a_done_idle, done_o |-> !busy, "result strobe while busy")

endmodule

@@ bench/dedup_table_newer_wins_fifo_evict_checker.sv @@
// scoreboard for the dedup table: mirrors the table contents and checks every result beat
`timescale 1ns / 1ps
module dedup_table_newer_wins_fifo_evict_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic        op_i,
  input  logic [3:0]  read_slot_i,
  input  logic [63:0] key_header_i,
  input  logic [63:0] parent_word0_i,
  input  logic [63:0] parent_word1_i,
  input  logic [63:0] parent_word2_i,
  input  logic [63:0] parent_word3_i,
  input  logic [63:0] origin_mask_i,
  input  logic [31:0] snapshot_age_i,
  input  logic [63:0] record_payload_i,
  input  logic        record_active_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i,
  input  logic        done_o,
  input  logic [2:0]  outcome_o,
  input  logic [3:0]  slot_o,
  input  logic [4:0]  entry_count_o,
  input  logic [63:0] rd_header_o,
  input  logic [63:0] rd_parent0_o,
  input  logic [63:0] rd_parent1_o,
  input  logic [63:0] rd_parent2_o,
  input  logic [63:0] rd_parent3_o,
  input  logic [63:0] rd_mask_o,
  input  logic [31:0] rd_age_o,
  input  logic [63:0] rd_payload_o,
  input  logic        rd_active_o,
  output int          mismatch_count_o,
  output int          outstanding_o
);
  import dtnw_pkg::*;

  typedef struct packed {
    outcome_e   outcome;
    logic [3:0] slot;
    logic [4:0] count;
    rec_t       rd;
  } table_result_t;

  rec_t          entries [DEPTH];
  int unsigned   fill_level;
  logic [4:0]    capacity;
  table_result_t pending_results [$];
  int            mismatches;
  int            outstanding;

  assign mismatch_count_o = mismatches;
  assign outstanding_o    = outstanding;

  function automatic int unsigned slots_in_use();
    int unsigned c;
    c = capacity;
    if (c < 1) c = 1;
    if (c > DEPTH) c = DEPTH;
    return c;
  endfunction

  function automatic bit same_key(rec_t a, rec_t b);
    return a.header == b.header && a.parent0 == b.parent0 && a.parent1 == b.parent1 &&
           a.parent2 == b.parent2 && a.parent3 == b.parent3 && a.mask == b.mask;
  endfunction

  // updates the mirrored table and queues the result this beat should produce
  function automatic void apply_command(op_e op, logic [3:0] rslot, rec_t rec);
    table_result_t res;
    int unsigned   lim;
    int unsigned   hit;
    bit            found;
    res   = '0;
    lim   = slots_in_use();
    found = 1'b0;
    hit   = 0;
    if (fill_level > lim) fill_level = lim;
    if (op == OP_READ) begin
      res.outcome = OC_READ;
      res.slot    = rslot;
      if (rslot < fill_level) res.rd = entries[rslot];
    end else begin
      for (int i = 0; i < DEPTH; i++) begin
        if (!found && i < fill_level && same_key(entries[i], rec)) begin
          found = 1'b1;
          hit   = i;
        end
      end
      if (found) begin
        res.slot = 4'(hit);
        if (rec.age >= entries[hit].age) begin
          entries[hit] = rec;
          res.outcome  = OC_REPLACED;
        end else begin
          res.outcome = OC_KEPT;
        end
      end else if (fill_level < lim) begin
        res.slot            = 4'(fill_level);
        entries[fill_level] = rec;
        fill_level++;
        res.outcome = OC_APPENDED;
      end else begin
        // oldest entry drops out, the rest move down one slot
        for (int i = 1; i < DEPTH; i++) begin
          if (i < lim) entries[i-1] = entries[i];
        end
        res.slot         = 4'(lim - 1);
        entries[lim - 1] = rec;
        res.outcome      = OC_EVICTED;
      end
    end
    res.count = 5'(fill_level);
    pending_results.push_back(res);
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rec_t          in_rec;
    table_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) entries[i] = '0;
      fill_level = 0;
      capacity   = CAP_RESET;
      pending_results.delete();
      mismatches  = 0;
      outstanding <= 0;
    end else begin
      // capacity only lands while the table is empty
      if (cfg_valid_i && cfg_ready_o && fill_level == 0) capacity = cfg_data_i;
      if (done_o) begin
        if (pending_results.size() == 0) begin
          $error("result beat with nothing outstanding: outcome %0h slot %0h",
                 outcome_o, slot_o);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("outcome", want.outcome, outcome_o);
          check_field("slot", want.slot, slot_o);
          check_field("entry_count", want.count, entry_count_o);
          check_field("rd_header", want.rd.header, rd_header_o);
          check_field("rd_parent0", want.rd.parent0, rd_parent0_o);
          check_field("rd_parent1", want.rd.parent1, rd_parent1_o);
          check_field("rd_parent2", want.rd.parent2, rd_parent2_o);
          check_field("rd_parent3", want.rd.parent3, rd_parent3_o);
          check_field("rd_mask", want.rd.mask, rd_mask_o);
          check_field("rd_age", want.rd.age, rd_age_o);
          check_field("rd_payload", want.rd.payload, rd_payload_o);
          check_field("rd_active", want.rd.active, rd_active_o);
        end
      end
      if (start && !busy) begin
        in_rec.header  = key_header_i;
        in_rec.parent0 = parent_word0_i;
        in_rec.parent1 = parent_word1_i;
        in_rec.parent2 = parent_word2_i;
        in_rec.parent3 = parent_word3_i;
        in_rec.mask    = origin_mask_i;
        in_rec.age     = snapshot_age_i;
        in_rec.payload = record_payload_i;
        in_rec.active  = record_active_i;
        apply_command(op_e'(op_i), read_slot_i, in_rec);
      end
      outstanding <= pending_results.size();
    end
  end

endmodule

@@ bench/dedup_table_newer_wins_fifo_evict_test.sv @@
// stimulus and verdict for the dedup table, with the scoreboard alongside the block
`timescale 1ns / 1ps
module dedup_table_newer_wins_fifo_evict_test;
  import dtnw_pkg::*;

  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        start            = 1'b0;
  logic        busy;
  logic        op_i             = 1'b0;
  logic [3:0]  read_slot_i      = '0;
  logic [63:0] key_header_i     = '0;
  logic [63:0] parent_word0_i   = '0;
  logic [63:0] parent_word1_i   = '0;
  logic [63:0] parent_word2_i   = '0;
  logic [63:0] parent_word3_i   = '0;
  logic [63:0] origin_mask_i    = '0;
  logic [31:0] snapshot_age_i   = '0;
  logic [63:0] record_payload_i = '0;
  logic        record_active_i  = 1'b0;
  logic        cfg_valid_i      = 1'b0;
  logic        cfg_ready_o;
  logic [4:0]  cfg_data_i       = '0;
  logic        done_o;
  logic [2:0]  outcome_o;
  logic [3:0]  slot_o;
  logic [4:0]  entry_count_o;
  logic [63:0] rd_header_o;
  logic [63:0] rd_parent0_o;
  logic [63:0] rd_parent1_o;
  logic [63:0] rd_parent2_o;
  logic [63:0] rd_parent3_o;
  logic [63:0] rd_mask_o;
  logic [31:0] rd_age_o;
  logic [63:0] rd_payload_o;
  logic        rd_active_o;
  int          mismatch_count_o;
  int          outstanding_o;

  int   idle_pct;
  int   idle_max;
  rec_t key_pool [24];

  dedup_table_newer_wins_fifo_evict i_dut (.*);

  dedup_table_newer_wins_fifo_evict_checker i_checker (.*);

  always #10 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("dedup_table_newer_wins_fifo_evict: mismatch");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic rec_t random_key();
    rec_t r;
    r         = '0;
    r.header  = rand64();
    r.parent0 = rand64();
    r.parent1 = rand64();
    r.parent2 = rand64();
    r.parent3 = rand64();
    r.mask    = rand64();
    return r;
  endfunction

  // flips one bit of one key field, so the key misses by the narrowest margin
  function automatic rec_t tweak_key(rec_t k, int field, int b);
    case (field)
      0:       k.header[b]  = ~k.header[b];
      1:       k.parent0[b] = ~k.parent0[b];
      2:       k.parent1[b] = ~k.parent1[b];
      3:       k.parent2[b] = ~k.parent2[b];
      4:       k.parent3[b] = ~k.parent3[b];
      default: k.mask[b]    = ~k.mask[b];
    endcase
    return k;
  endfunction

  function automatic logic [31:0] pick_age();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom();
      default: return $urandom_range(0, 15);
    endcase
  endfunction

  task automatic drive_item(op_e op, logic [3:0] rslot, rec_t rec);
    start            <= 1'b1;
    op_i             <= op;
    read_slot_i      <= rslot;
    key_header_i     <= rec.header;
    parent_word0_i   <= rec.parent0;
    parent_word1_i   <= rec.parent1;
    parent_word2_i   <= rec.parent2;
    parent_word3_i   <= rec.parent3;
    origin_mask_i    <= rec.mask;
    snapshot_age_i   <= rec.age;
    record_payload_i <= rec.payload;
    record_active_i  <= rec.active;
    do @(posedge clk_i); while (busy);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, idle_max)) @(posedge clk_i);
    end
  endtask

  task automatic random_item();
    rec_t k;
    if ($urandom_range(0, 99) < 20) begin
      drive_item(OP_READ, 4'($urandom_range(0, 15)), random_key());
    end else begin
      k = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, 23)] : random_key();
      k.age     = pick_age();
      k.payload = rand64();
      k.active  = 1'($urandom_range(0, 1));
      drive_item(OP_INSERT, 4'($urandom_range(0, 15)), k);
    end
  endtask

  // valid stays up across back-to-back beats and drops after the last one
  task automatic write_capacity(logic [4:0] value, bit last_beat);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (last_beat) cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    @(posedge clk_i);
    while (outstanding_o != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    rec_t        base;
    rec_t        k;
    logic [4:0]  cap_choice;
    idle_pct = 30;
    idle_max = 3;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // out-of-range values first, the last write before any insert sticks
    case ($urandom_range(0, 5))
      0:       cap_choice = 5'd0;
      1:       cap_choice = 5'd31;
      2:       cap_choice = 5'd1;
      3:       cap_choice = 5'd16;
      default: cap_choice = 5'($urandom_range(2, 15));
    endcase
    write_capacity(5'd31, 1'b0);
    write_capacity(5'd0, 1'b0);
    write_capacity(5'd17, 1'b0);
    write_capacity(5'd1, 1'b0);
    write_capacity(cap_choice, 1'b1);

    for (int i = 0; i < 12; i++) key_pool[i] = random_key();
    for (int i = 12; i < 24; i++) begin
      key_pool[i] = tweak_key(key_pool[i-12], $urandom_range(0, 5), $urandom_range(0, 63));
    end

    // reads of an empty table
    base = random_key();
    drive_item(OP_READ, 4'd0, base);
    drive_item(OP_READ, 4'd15, base);
    // same key: tie replaces, older is kept, payload and active do not matter
    k         = base;
    k.age     = 32'd100;
    k.payload = rand64();
    k.active  = 1'b1;
    drive_item(OP_INSERT, 4'd0, k);
    k.payload = ~k.payload;
    k.active  = 1'b0;
    drive_item(OP_INSERT, 4'd0, k);
    k.age = 32'd99;
    drive_item(OP_INSERT, 4'd0, k);
    k.age = '1;
    drive_item(OP_INSERT, 4'd0, k);
    k.age = '0;
    drive_item(OP_INSERT, 4'd0, k);
    // near misses in each key field
    for (int f = 0; f < 6; f++) begin
      k         = tweak_key(base, f, $urandom_range(0, 63));
      k.age     = $urandom();
      k.payload = rand64();
      k.active  = 1'($urandom_range(0, 1));
      drive_item(OP_INSERT, 4'd0, k);
    end
    k = '1;
    drive_item(OP_INSERT, 4'd15, k);
    k = '0;
    drive_item(OP_INSERT, 4'd0, k);
    drive_item(OP_READ, 4'd0, k);
    drive_item(OP_READ, 4'd1, k);
    drive_item(OP_READ, 4'd2, k);
    drive_item(OP_READ, 4'd3, k);
    drive_item(OP_READ, 4'd15, k);
    start <= 1'b0;

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          idle_pct = 30;
          idle_max = 3;
        end
        1: begin
          idle_pct = 78;
          idle_max = 6;
        end
        default: begin
          idle_pct = 0;
          idle_max = 1;
        end
      endcase
      // table is not empty here, so this write must have no effect
      wait_idle();
      case ($urandom_range(0, 2))
        0:       write_capacity(5'd0, 1'b1);
        1:       write_capacity(5'd31, 1'b1);
        default: write_capacity(5'($urandom_range(1, 16)), 1'b1);
      endcase
      repeat (470) random_item();
      start <= 1'b0;
    end

    wait_idle();
    if (mismatch_count_o == 0 && outstanding_o == 0) begin
      $display("dedup_table_newer_wins_fifo_evict: match");
    end else begin
      $display("dedup_table_newer_wins_fifo_evict: mismatch");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/dtnw_pkg.sv
design/dtnw_cell.sv
design/dedup_table_newer_wins_fifo_evict.sv
bench/dedup_table_newer_wins_fifo_evict_checker.sv
bench/dedup_table_newer_wins_fifo_evict_test.sv
